>>> hw/rtl/first_fit_region_allocator_assert.svh
// Assertion macros for the region allocator checker.
// The using module provides clk and arst_n.
`ifndef FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define FFRA_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("ffra assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define FFRA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffra assertion failed");

// Consequent holds in the cycle after the antecedent.
`define FFRA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffra assertion failed");

`endif

>>> hw/rtl/ffra_pkg.sv
package ffra_pkg;

	localparam int MAX_REGIONS = 64;
	localparam int IDX_W       = $clog2(MAX_REGIONS);
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

	localparam logic [31:0] REGION_SIZE_RST = 32'd65536;

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	localparam logic [2:0] STAT_OK            = 3'd0;
	localparam logic [2:0] STAT_NO_FIT        = 3'd1;
	localparam logic [2:0] STAT_NOT_ALLOCATED = 3'd2;
	localparam logic [2:0] STAT_TABLE_FULL    = 3'd3;
	localparam logic [2:0] STAT_ZERO_SIZE     = 3'd4;

	typedef struct packed {
		logic        mode;
		logic [31:0] request_size;
		logic [31:0] release_address;
	} ffra_req_t;

	typedef struct packed {
		logic [31:0] address;
		logic [2:0]  status;
	} ffra_rsp_t;

	// table entry: size in the upper word, start in the lower
	typedef struct packed {
		logic [31:0] size;
		logic [31:0] start;
	} ffra_entry_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} ffra_state_t;

endpackage

>>> hw/rtl/first_fit_region_allocator.sv
// First-fit region allocator. Keeps a free table and a used table of MAX_REGIONS
// entries (64) over one region of region_size bytes. An allocate request takes the
// lowest-addressed free region that is large enough, records it as used and trims
// the free entry from the front (removes it on an exact fit); a release request
// finds the used entry by start address and moves it back to the free table
// without merging neighbors. Each request answers with exactly one response
// (address, status). After the edge that accepts a request the block scans the
// tables: one table entry is read and compared per cycle through the single read
// port of each table; the reads are registered and a decision cycle follows the
// last compare. req_stall stays high for that whole time, so the next request is
// taken only after the previous one has been decided. The decision cycle waits
// while an earlier response is still held by rsp_stall; the response register
// lets the next request in while the previous response waits. A write to
// region_size needs no clearing pass and puts the tables back to one free region
// [0, region_size) (none if the size is zero).
module first_fit_region_allocator import ffra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  ffra_req_t   req_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output ffra_rsp_t   rsp_data,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	// control state
	ffra_state_t            state_q;
	logic [CNT_W-1:0]       cnt_q;          // scan read address / step count
	logic                   rd_valid_s1;    // read data of this cycle belongs to the scan
	logic [IDX_W-1:0]       rd_idx_s1;
	logic [31:0]            region_size_q;
	logic                   fresh_q;        // free entry 0 still holds the initial region
	logic [MAX_REGIONS-1:0] free_valid_q;
	logic [MAX_REGIONS-1:0] used_valid_q;
	logic                   hit_q;          // fitting region (allocate) or match (release) found
	logic                   slot_found_q;   // empty slot in the target table found
	logic                   rsp_valid_q;

	// payload
	ffra_req_t              req_q;
	ffra_entry_t            hit_entry_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [IDX_W-1:0]       slot_idx_q;
	ffra_rsp_t              rsp_q;

	// tables (used table contents are only read under its valid bit)
	ffra_entry_t free_mem [MAX_REGIONS];
	ffra_entry_t used_mem [MAX_REGIONS];
	ffra_entry_t free_rd_s1;
	ffra_entry_t used_rd_s1;

	// write side, driven in the decision cycle
	logic             free_we;
	logic [IDX_W-1:0] free_wa;
	ffra_entry_t      free_wd;
	logic             used_we;
	ffra_entry_t      used_wd;
	logic             free_set;
	logic             free_clr;
	logic             used_set;
	logic             used_clr;

	logic        scan_last;
	logic        commit;
	ffra_entry_t free_eff;
	logic        fit_take;
	logic        match_take;
	logic        slot_take;
	logic        exact_fit;
	logic [2:0]  res_status;
	logic [31:0] res_addr;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign scan_last = (cnt_q == CNT_W'(MAX_REGIONS));
	// the decision cycle retires only when the response register can take the result
	assign commit    = (state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall);

	// table memories: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (free_we) begin
			free_mem[free_wa] <= free_wd;
		end
		if (used_we) begin
			used_mem[slot_idx_q] <= used_wd;
		end
		free_rd_s1 <= free_mem[cnt_q[IDX_W-1:0]];
		used_rd_s1 <= used_mem[cnt_q[IDX_W-1:0]];
	end

	// entry 0 reads as the configured region until it is first rewritten
	always_comb begin
		free_eff = free_rd_s1;
		if (fresh_q && (rd_idx_s1 == '0)) begin
			free_eff.size  = region_size_q;
			free_eff.start = '0;
		end
	end

	// per-entry compare, shared by both request kinds
	always_comb begin
		fit_take   = 1'b0;
		match_take = 1'b0;
		slot_take  = 1'b0;
		if (rd_valid_s1) begin
			if (req_q.mode == MODE_ALLOC) begin
				fit_take  = free_valid_q[rd_idx_s1]
					&& (free_eff.size >= req_q.request_size)
					&& (!hit_q || (free_eff.start < hit_entry_q.start));
				slot_take = !used_valid_q[rd_idx_s1] && !slot_found_q;
			end else begin
				match_take = used_valid_q[rd_idx_s1] && !hit_q
					&& (used_rd_s1.start == req_q.release_address);
				slot_take  = !free_valid_q[rd_idx_s1] && !slot_found_q;
			end
		end
	end

	assign exact_fit = (hit_entry_q.size == req_q.request_size);

	// decision: status, address and table updates
	always_comb begin
		res_status    = STAT_OK;
		res_addr      = '0;
		free_we       = 1'b0;
		free_wa       = hit_idx_q;
		free_wd.size  = hit_entry_q.size - req_q.request_size;
		free_wd.start = hit_entry_q.start + req_q.request_size;
		used_we       = 1'b0;
		used_wd.size  = req_q.request_size;
		used_wd.start = hit_entry_q.start;
		free_set      = 1'b0;
		free_clr      = 1'b0;
		used_set      = 1'b0;
		used_clr      = 1'b0;
		if (req_q.mode == MODE_ALLOC) begin
			if (req_q.request_size == '0) begin
				res_status = STAT_ZERO_SIZE;
			end else if (!hit_q) begin
				res_status = STAT_NO_FIT;
			end else if (!slot_found_q) begin
				res_status = STAT_TABLE_FULL;
			end else begin
				res_addr = hit_entry_q.start;
				used_we  = commit;
				used_set = commit;
				if (exact_fit) begin
					free_clr = commit;
				end else begin
					free_we = commit;
				end
			end
		end else begin
			if (!hit_q) begin
				res_status = STAT_NOT_ALLOCATED;
			end else if (!slot_found_q) begin
				res_status = STAT_TABLE_FULL;
			end else begin
				free_wa  = slot_idx_q;
				free_wd  = hit_entry_q;
				free_we  = commit;
				free_set = commit;
				used_clr = commit;
			end
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			rd_valid_s1   <= 1'b0;
			region_size_q <= REGION_SIZE_RST;
			fresh_q       <= 1'b1;
			free_valid_q  <= {{(MAX_REGIONS-1){1'b0}}, 1'b1};
			used_valid_q  <= '0;
			hit_q         <= 1'b0;
			slot_found_q  <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_SCAN) && !scan_last;

			if (rsp_valid_q && !rsp_stall && !commit) begin
				rsp_valid_q <= 1'b0;
			end
			if (fit_take || match_take) begin
				hit_q <= 1'b1;
			end
			if (slot_take) begin
				slot_found_q <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cnt_q        <= '0;
						hit_q        <= 1'b0;
						slot_found_q <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					// last read data is compared in the cycle cnt_q reaches the end
					if (scan_last) begin
						state_q <= S_FINISH;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_FINISH: begin
					if (commit) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (free_set) begin
				free_valid_q[slot_idx_q] <= 1'b1;
			end
			if (free_clr) begin
				free_valid_q[hit_idx_q] <= 1'b0;
			end
			if (used_set) begin
				used_valid_q[slot_idx_q] <= 1'b1;
			end
			if (used_clr) begin
				used_valid_q[hit_idx_q] <= 1'b0;
			end
			if (free_we && (free_wa == '0)) begin
				fresh_q <= 1'b0;
			end

			// region resize: back to one free region, no used regions
			if (cfg_we) begin
				region_size_q <= cfg_wdata;
				fresh_q       <= 1'b1;
				free_valid_q  <= {{(MAX_REGIONS-1){1'b0}}, (cfg_wdata != '0)};
				used_valid_q  <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IDX_W-1:0];
		if ((state_q == S_IDLE) && req_valid) begin
			req_q <= req_data;
		end
		if (fit_take) begin
			hit_entry_q <= free_eff;
			hit_idx_q   <= rd_idx_s1;
		end
		if (match_take) begin
			hit_entry_q <= used_rd_s1;
			hit_idx_q   <= rd_idx_s1;
		end
		if (slot_take) begin
			slot_idx_q <= rd_idx_s1;
		end
		if (commit) begin
			rsp_q.address <= res_addr;
			rsp_q.status  <= res_status;
		end
	end

endmodule

>>> hw/rtl/ffra_checker.sv
`include "first_fit_region_allocator_assert.svh"

module ffra_checker import ffra_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input ffra_rsp_t   rsp_data
);

	// busy right after taking a request
	`FFRA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

	// status code is one of the defined ones
	`FFRA_ASSERT_SAME(a_status_range, rsp_valid, rsp_data.status <= STAT_ZERO_SIZE)

	// failed requests report address zero
	`FFRA_ASSERT_SAME(a_fail_addr_zero, rsp_valid && (rsp_data.status != STAT_OK),
		rsp_data.address == '0)

	// a stalled response holds
	`FFRA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ffra_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	ffra_req_t   req_data;
	logic        rsp_valid;
	logic        rsp_stall;
	ffra_rsp_t   rsp_data;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	first_fit_region_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// 100 MHz
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow allocator: our own copy of both tables and the region size.
	// Updated in request order at the edge where the DUT accepts a request.
	// ------------------------------------------------------------------
	logic [31:0] shadow_region_size;
	ffra_entry_t free_regions [MAX_REGIONS];
	logic        free_live    [MAX_REGIONS];
	ffra_entry_t used_regions [MAX_REGIONS];
	logic        used_live    [MAX_REGIONS];

	// predicted responses, oldest first
	ffra_rsp_t   outcome_q[$];
	ffra_rsp_t   oldest_outcome;
	int          mismatch_count;

	// idling knobs, percent of cycles
	int          sender_idle_pct;
	int          receiver_stall_pct;

	// receiver hold-off: the test posts a length, the stall process counts it down
	int          holdoff_request;
	int          holdoff_left;

	// region_size write puts the tables back to one free region (none if size is 0)
	function automatic void clear_regions(logic [31:0] sz);
		shadow_region_size = sz;
		for (int i = 0; i < MAX_REGIONS; i++) begin
			free_regions[i] = '0;
			free_live[i]    = 1'b0;
			used_regions[i] = '0;
			used_live[i]    = 1'b0;
		end
		if (sz != 0) begin
			free_regions[0].start = '0;
			free_regions[0].size  = sz;
			free_live[0]          = 1'b1;
		end
	endfunction

	// Applies one request to the shadow tables and returns the response it
	// should produce. Allocate: lowest-start fitting free region, first empty
	// used slot. Release: first used entry with matching start, first empty
	// free slot, no merging.
	function automatic ffra_rsp_t predict_outcome(ffra_req_t r);
		ffra_rsp_t rsp;
		int        best;
		int        slot;
		int        hit;
		rsp.address = '0;
		rsp.status  = STAT_OK;
		best = -1;
		slot = -1;
		hit  = -1;
		if (r.mode == MODE_ALLOC) begin
			if (r.request_size == 0) begin
				rsp.status = STAT_ZERO_SIZE;
			end else begin
				for (int i = 0; i < MAX_REGIONS; i++) begin
					if (free_live[i] && free_regions[i].size >= r.request_size &&
					    (best < 0 || free_regions[i].start < free_regions[best].start))
						best = i;
					if (slot < 0 && !used_live[i])
						slot = i;
				end
				if (best < 0) begin
					rsp.status = STAT_NO_FIT;
				end else if (slot < 0) begin
					rsp.status = STAT_TABLE_FULL;
				end else begin
					rsp.address             = free_regions[best].start;
					used_regions[slot].start = free_regions[best].start;
					used_regions[slot].size  = r.request_size;
					used_live[slot]          = 1'b1;
					if (free_regions[best].size == r.request_size) begin
						free_regions[best] = '0;
						free_live[best]    = 1'b0;
					end else begin
						free_regions[best].start += r.request_size;
						free_regions[best].size  -= r.request_size;
					end
				end
			end
		end else begin
			for (int i = 0; i < MAX_REGIONS; i++) begin
				if (hit < 0 && used_live[i] && used_regions[i].start == r.release_address)
					hit = i;
				if (slot < 0 && !free_live[i])
					slot = i;
			end
			if (hit < 0) begin
				rsp.status = STAT_NOT_ALLOCATED;
			end else if (slot < 0) begin
				// free table full: block stays allocated
				rsp.status = STAT_TABLE_FULL;
			end else begin
				free_regions[slot] = used_regions[hit];
				free_live[slot]    = 1'b1;
				used_regions[hit]  = '0;
				used_live[hit]     = 1'b0;
			end
		end
		return rsp;
	endfunction

	// random start address of a block that is currently allocated
	function automatic bit pick_live_block(output logic [31:0] start);
		int idx[$];
		start = '0;
		for (int i = 0; i < MAX_REGIONS; i++)
			if (used_live[i])
				idx.push_back(i);
		if (idx.size() == 0)
			return 1'b0;
		start = used_regions[idx[$urandom_range(idx.size() - 1, 0)]].start;
		return 1'b1;
	endfunction

	// size of the largest free region, for exact-fit requests
	function automatic logic [31:0] largest_free_size();
		logic [31:0] biggest;
		biggest = '0;
		for (int i = 0; i < MAX_REGIONS; i++)
			if (free_live[i] && free_regions[i].size > biggest)
				biggest = free_regions[i].size;
		return biggest;
	endfunction

	function automatic ffra_req_t make_request(logic op, logic [31:0] sz, logic [31:0] addr);
		ffra_req_t r;
		r.mode            = op;
		r.request_size    = sz;
		r.release_address = addr;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Offers one request and returns at the edge where it is taken. Valid stays
	// high on return so back-to-back requests need no extra cycle.
	task automatic send_request(input ffra_req_t r);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		outcome_q.push_back(predict_outcome(r));
	endtask

	task automatic request_alloc(input logic [31:0] sz);
		send_request(make_request(MODE_ALLOC, sz, $urandom));
	endtask

	task automatic request_release(input logic [31:0] addr);
		send_request(make_request(MODE_RELEASE, $urandom, addr));
	endtask

	// Drop valid and wait until every predicted response has been taken.
	// Always waits on a clock edge first so NBAs of the caller never collide.
	task automatic wait_responses_done();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	// region_size write, only with the block idle
	task automatic write_region_size(input logic [31:0] sz);
		wait_responses_done();
		cfg_we    <= 1'b1;
		cfg_wdata <= sz;
		@(posedge clk);
		cfg_we    <= 1'b0;
		clear_regions(sz);
	endtask

	// ------------------------------------------------------------------
	// Response side
	// ------------------------------------------------------------------

	// Stall generator; a posted hold-off overrides the random stalls.
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_request != 0) begin
				holdoff_left    = holdoff_request;
				holdoff_request = 0;
			end
			if (holdoff_left != 0) begin
				holdoff_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= (receiver_stall_pct != 0) &&
				             ($urandom_range(99) < receiver_stall_pct);
			end
		end
	end

	// Checker: every taken response against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (outcome_q.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: unexpected response address %h status %0d",
					         $time, rsp_data.address, rsp_data.status);
				mismatch_count++;
			end else begin
				oldest_outcome = outcome_q.pop_front();
				if (rsp_data.address !== oldest_outcome.address ||
				    rsp_data.status !== oldest_outcome.status) begin
					if (mismatch_count < 10)
						$display("%0t: mismatch address exp %h got %h, status exp %0d got %0d",
						         $time, oldest_outcome.address, rsp_data.address,
						         oldest_outcome.status, rsp_data.status);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset size (65536): zero size, no fit, exact fit, unknown address,
	// double release, lowest-start choice among several free regions.
	task automatic test_directed_alloc_release();
		request_alloc(32'd0);            // zero size
		request_alloc(32'd100);          // -> 0
		request_alloc(32'hFFFF_FFFF);    // no fit
		request_alloc(32'd65436);        // exact fit of the rest -> 100
		request_alloc(32'd1);            // free table empty: no fit
		request_release(32'd0);
		request_release(32'd0);          // already released
		request_release(32'hFFFF_FFFF);  // never allocated
		request_alloc(32'd50);           // -> 0, trims (0,100)
		request_release(32'd100);
		request_alloc(32'd65436);        // skips (50,50), takes 100
		request_release(32'd50);         // start of a free region, not a used one
		request_alloc(32'd50);           // exact fit -> 50
	endtask

	// Empty region, one-byte region, full 32-bit region.
	task automatic test_region_size_extremes();
		write_region_size(32'd0);
		request_alloc(32'd1);
		request_alloc(32'd0);
		request_alloc(32'hFFFF_FFFF);
		request_release(32'd0);
		write_region_size(32'd1);
		request_alloc(32'd2);
		request_alloc(32'd1);
		request_alloc(32'd1);
		request_release(32'd0);
		request_alloc(32'd1);
		write_region_size(32'hFFFF_FFFF);
		request_alloc(32'hFFFF_FFFF);
		request_alloc(32'd1);
		request_release(32'd0);
		request_alloc(32'h8000_0000);
		request_alloc(32'h7FFF_FFFF);
		request_alloc(32'd1);
	endtask

	// Fill the used table, then release everything in random order so the
	// free table fills up (no merging) and the last release bounces.
	task automatic test_table_capacity();
		logic [31:0] starts[$];
		logic [31:0] tmp;
		int          j;
		write_region_size($urandom_range(100000, 5000));
		for (int i = 0; i < MAX_REGIONS; i++)
			request_alloc($urandom_range(64, 1));
		request_alloc(32'hFFFF_FFFF);    // no fit wins over table full
		request_alloc(32'd1);            // used table full
		for (int i = 0; i < MAX_REGIONS; i++)
			if (used_live[i])
				starts.push_back(used_regions[i].start);
		for (int i = starts.size() - 1; i > 0; i--) begin
			j         = $urandom_range(i, 0);
			tmp       = starts[i];
			starts[i] = starts[j];
			starts[j] = tmp;
		end
		foreach (starts[i])
			request_release(starts[i]);  // last one: free table full
		request_release(starts[starts.size() - 1]);
		// fragmented free table: first fit among many small regions
		for (int i = 0; i < 12; i++)
			request_alloc($urandom_range(64, 1));
		foreach (starts[i])
			request_release(starts[i]);
	endtask

	// Receiver holds off while the sender keeps offering; the block fills
	// and stalls requests. Then the sender pauses for a full drain.
	task automatic test_receiver_holdoff();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		write_region_size(32'd4096);
		holdoff_request = 600;
		for (int i = 0; i < 8; i++)
			request_alloc($urandom_range(300, 1));
		wait_responses_done();
		for (int i = 0; i < 4; i++)
			request_release(i * 16);
	endtask

	// Mostly well-formed traffic: allocs sized to the region, releases of live
	// blocks; the rest zero sizes, full-range sizes, exact fits, bogus addresses.
	task automatic send_random_request();
		ffra_req_t   r;
		int          pick;
		logic [31:0] cap;
		logic [31:0] addr;
		r    = make_request(MODE_ALLOC, $urandom, $urandom);
		pick = $urandom_range(99);
		cap  = shadow_region_size / 12;
		if (cap == 0)
			cap = 1;
		if (pick < 40) begin
			r.request_size = $urandom_range(cap, 1);
		end else if (pick < 44) begin
			r.request_size = '0;
		end else if (pick < 48) begin
			// full-range size already in place
		end else if (pick < 53) begin
			r.request_size = largest_free_size();
		end else if (pick < 90) begin
			r.mode = MODE_RELEASE;
			if (pick_live_block(addr))
				r.release_address = addr;
		end else begin
			r.mode = MODE_RELEASE;
			if (pick < 95 && pick_live_block(addr))
				r.release_address = addr + 1;
		end
		send_request(r);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
	                                   input int count);
		logic [31:0] sz;
		case ($urandom_range(3))
			0:       sz = $urandom_range(4096, 64);
			1:       sz = $urandom_range(200000, 4096);
			2:       sz = $urandom;
			default: sz = 32'hFFFF_FFFF;
		endcase
		write_region_size(sz);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (count)
			send_random_request();
		wait_responses_done();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n             <= 1'b0;
		req_valid          <= 1'b0;
		req_data           <= '0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		mismatch_count     = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		holdoff_request    = 0;
		holdoff_left       = 0;
		clear_regions(REGION_SIZE_RST);
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_alloc_release();
		test_region_size_extremes();
		test_table_capacity();
		test_receiver_holdoff();
		test_random_traffic(0, 0, 75);
		test_random_traffic(88, 0, 75);
		test_random_traffic(0, 88, 75);
		test_random_traffic(30, 30, 75);

		wait_responses_done();
		// a stray response would show up within one request latency
		repeat (80)
			@(posedge clk);
		mismatch_count += outcome_q.size();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// hang guard: several times the slowest legal run
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ffra_pkg.sv
hw/rtl/first_fit_region_allocator.sv
hw/rtl/ffra_checker.sv
dv/testbench.sv
